// ----- rtl/core/slc_pkg.sv -----
// shared types, constants and helpers for the source line classifier
package slc_pkg;

  localparam int COUNT_WIDTH  = 32;
  localparam int REPORT_WIDTH = 32;
  localparam int EXT_WIDTH    = (COUNT_WIDTH > REPORT_WIDTH) ? COUNT_WIDTH : REPORT_WIDTH;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;

  typedef enum logic [2:0] {
    ST_EMPTY    = 3'd0,
    ST_CODE     = 3'd1,
    ST_SLASH    = 3'd2,
    ST_SINGLE   = 3'd3,
    ST_BLK_IN   = 3'd4,
    ST_BLK_STAR = 3'd5,
    ST_BLK_DONE = 3'd6
  } line_state_e;

  typedef enum logic [1:0] {
    CLS_EMPTY     = 2'd0,
    CLS_CODE      = 2'd1,
    CLS_COMMENT   = 2'd2,
    CLS_UNCOUNTED = 2'd3
  } line_class_e;

  typedef struct packed {
    logic code;
    logic comment;
    logic empty;
    logic total;
  } count_inc_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // low report bits of a counter, zero extended when the counter is narrower
  function automatic logic [REPORT_WIDTH-1:0] to_report(count_t v);
    logic [EXT_WIDTH-1:0] ext;
    ext = EXT_WIDTH'(v);
    return ext[REPORT_WIDTH-1:0];
  endfunction

endpackage

// ----- rtl/core/slc_line_fsm.sv -----
// line state machine: tracks comment context and classifies each line at newline
module slc_line_fsm import slc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  ch_i,
  output line_class_e line_class_o,
  output count_inc_t  inc_o
);

  line_state_e state_q, state_d;
  logic        is_nl;

  assign is_nl = (ch_i == CH_NL);

  always_comb begin
    state_d = state_q;
    if (is_nl) begin
      unique case (state_q)
        ST_CODE, ST_SINGLE, ST_BLK_DONE: state_d = ST_EMPTY;
        ST_SLASH:                        state_d = ST_SLASH;
        ST_BLK_IN, ST_BLK_STAR:          state_d = ST_BLK_IN;
        default:                         state_d = ST_EMPTY;
      endcase
    end else begin
      unique case (state_q)
        ST_CODE, ST_SINGLE, ST_BLK_DONE: state_d = state_q;
        ST_SLASH: begin
          if (ch_i == CH_SLASH)     state_d = ST_SINGLE;
          else if (ch_i == CH_STAR) state_d = ST_BLK_IN;
          else                      state_d = ST_CODE;
        end
        ST_BLK_IN:   state_d = (ch_i == CH_STAR) ? ST_BLK_STAR : ST_BLK_IN;
        ST_BLK_STAR: state_d = (ch_i == CH_SLASH) ? ST_BLK_DONE : ST_BLK_IN;
        default: begin
          if (ch_i == CH_SPACE || ch_i == CH_LBRACE || ch_i == CH_RBRACE) begin
            state_d = ST_EMPTY;
          end else if (ch_i == CH_SLASH) begin
            state_d = ST_SLASH;
          end else begin
            state_d = ST_CODE;
          end
        end
      endcase
    end
  end

  // class and counter bumps only matter on a newline
  always_comb begin
    inc_o       = '0;
    inc_o.total = is_nl;
    unique case (state_q)
      ST_CODE: begin
        line_class_o = CLS_CODE;
        inc_o.code   = is_nl;
      end
      ST_SLASH: begin
        line_class_o = CLS_UNCOUNTED;
      end
      ST_SINGLE, ST_BLK_DONE, ST_BLK_IN, ST_BLK_STAR: begin
        line_class_o  = CLS_COMMENT;
        inc_o.comment = is_nl;
      end
      default: begin
        line_class_o = CLS_EMPTY;
        inc_o.empty  = is_nl;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/slc_counters.sv -----
// saturating line counters
module slc_counters import slc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  count_inc_t inc_i,
  output count_t     code_o,
  output count_t     comment_o,
  output count_t     empty_o,
  output count_t     total_o
);

  count_t code_q, comment_q, empty_q, total_q;
  count_t code_d, comment_d, empty_d, total_d;

  function automatic count_t sat_inc(count_t v, logic en);
    return (en && v != '1) ? v + count_t'(1) : v;
  endfunction

  assign code_d    = sat_inc(code_q, inc_i.code);
  assign comment_d = sat_inc(comment_q, inc_i.comment);
  assign empty_d   = sat_inc(empty_q, inc_i.empty);
  assign total_d   = sat_inc(total_q, inc_i.total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q    <= '0;
      comment_q <= '0;
      empty_q   <= '0;
      total_q   <= '0;
    end else if (step_i) begin
      code_q    <= code_d;
      comment_q <= comment_d;
      empty_q   <= empty_d;
      total_q   <= total_d;
    end
  end

  assign code_o    = code_q;
  assign comment_o = comment_q;
  assign empty_o   = empty_q;
  assign total_o   = total_q;

endmodule

// ----- rtl/core/source_line_classifier.sv -----
// top level: byte input register, line state machine, counters and result register
//
// Source line classifier. Takes one byte of C text per request and, for every
// newline byte, returns the line's class (empty, code, comment, or uncounted when
// the line ended right after a lone slash) with the running code, comment, empty
// and total line counts, which saturate. Other bytes return nothing. One byte is
// taken every cycle unless stalled; a newline's result is loaded into the result
// register as the newline leaves the byte register. The byte register only holds
// when a newline finds the result register still occupied and stalled; the counters
// themselves are the result payload, so they change only when a result is loaded.
module source_line_classifier import slc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  line_class_o,
  output logic [31:0] code_lines_o,
  output logic [31:0] cmt_lines_o,
  output logic [31:0] blank_lines_o,
  output logic [31:0] all_lines_o
);

  logic        byte_valid_q;
  logic [7:0]  ch_q;
  logic        byte_nl;
  logic        step;
  logic        in_take;
  logic        out_free;
  logic        out_valid_q, out_valid_d;
  line_class_e cls, cls_q;
  count_inc_t  inc;
  count_t      code_cnt, comment_cnt, empty_cnt, total_cnt;

  assign byte_nl  = (ch_q == CH_NL);
  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = byte_valid_q && (!byte_nl || out_free);
  assign in_stall_o = byte_valid_q && !step;
  assign in_take  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q <= ch_i;
    end
  end

  slc_line_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .ch_i         (ch_q),
    .line_class_o (cls),
    .inc_o        (inc)
  );

  slc_counters u_cnt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .inc_i     (inc),
    .code_o    (code_cnt),
    .comment_o (comment_cnt),
    .empty_o   (empty_cnt),
    .total_o   (total_cnt)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (step && byte_nl) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && byte_nl) begin
      cls_q <= cls;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_class_o    = cls_q;
  assign code_lines_o    = to_report(code_cnt);
  assign cmt_lines_o     = to_report(comment_cnt);
  assign blank_lines_o   = to_report(empty_cnt);
  assign all_lines_o     = to_report(total_cnt);

endmodule

// ----- rtl/core/slc_checker.sv -----
// port-level checker for the source line classifier, bound to the top level
module slc_checker import slc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  ch_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  line_class_o,
  input logic [31:0] code_lines_o,
  input logic [31:0] cmt_lines_o,
  input logic [31:0] blank_lines_o,
  input logic [31:0] all_lines_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_class_o)
      && $stable(all_lines_o) && $stable(code_lines_o))
    else $error("stalled result changed");

  // a fresh result needs an earlier newline request
  a_rise_after_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && ch_i == CH_NL, 2))
    else $error("result without a newline request");

  // a code line result always shows a nonzero code count
  a_code_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_class_o == CLS_CODE |-> code_lines_o != '0)
    else $error("code result with zero code count");

  // a comment line result always shows a nonzero comment count
  a_comment_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_class_o == CLS_COMMENT |-> cmt_lines_o != '0)
    else $error("comment result with zero comment count");

endmodule

bind source_line_classifier slc_checker u_slc_checker (.*);

// ----- test/line_count_checker.sv -----
// checker for the line classifier: follows each byte, predicts each line report, compares
`timescale 1ns / 1ps
module line_count_checker import slc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  line_class_i,
  input  logic [31:0] code_lines_i,
  input  logic [31:0] cmt_lines_i,
  input  logic [31:0] blank_lines_i,
  input  logic [31:0] all_lines_i,
  output int          mismatch_count_o,
  output int          pending_lines_o
);

  typedef struct packed {
    line_class_e cls;
    logic [31:0] code;
    logic [31:0] comment;
    logic [31:0] blank;
    logic [31:0] total;
  } line_report_t;

  line_state_e  line_st;
  count_t       code_n, comment_n, blank_n, total_n;
  line_report_t line_reports_q [$];
  line_report_t want;
  int           mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic count_t bump(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic take_byte(input logic [7:0] c);
    line_report_t rpt;
    if (c != CH_NL) begin
      case (line_st)
        ST_CODE, ST_SINGLE, ST_BLK_DONE: ;
        ST_SLASH:
          line_st = (c == CH_SLASH) ? ST_SINGLE : (c == CH_STAR) ? ST_BLK_IN : ST_CODE;
        ST_BLK_IN: if (c == CH_STAR) line_st = ST_BLK_STAR;
        // a second star falls back, so only star then slash closes
        ST_BLK_STAR: line_st = (c == CH_SLASH) ? ST_BLK_DONE : ST_BLK_IN;
        default: begin
          if (c == CH_SPACE || c == CH_LBRACE || c == CH_RBRACE) line_st = ST_EMPTY;
          else if (c == CH_SLASH) line_st = ST_SLASH;
          else line_st = ST_CODE;
        end
      endcase
    end else begin
      case (line_st)
        ST_CODE: begin
          code_n = bump(code_n);
          line_st = ST_EMPTY;
          rpt.cls = CLS_CODE;
        end
        // lone slash: only the total moves and the slash carries over
        ST_SLASH: rpt.cls = CLS_UNCOUNTED;
        ST_SINGLE, ST_BLK_DONE: begin
          comment_n = bump(comment_n);
          line_st = ST_EMPTY;
          rpt.cls = CLS_COMMENT;
        end
        ST_BLK_IN, ST_BLK_STAR: begin
          comment_n = bump(comment_n);
          line_st = ST_BLK_IN;
          rpt.cls = CLS_COMMENT;
        end
        default: begin
          blank_n = bump(blank_n);
          line_st = ST_EMPTY;
          rpt.cls = CLS_EMPTY;
        end
      endcase
      total_n = bump(total_n);
      rpt.code    = 32'(code_n);
      rpt.comment = 32'(comment_n);
      rpt.blank   = 32'(blank_n);
      rpt.total   = 32'(total_n);
      line_reports_q.push_back(rpt);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_st = ST_EMPTY;
      code_n = '0;
      comment_n = '0;
      blank_n = '0;
      total_n = '0;
      line_reports_q.delete();
      pending_lines_o = 0;
    end else begin
      // the result leaving now belongs to an earlier byte, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (line_reports_q.size() == 0) begin
          mismatches++;
          $display("%0t: line report with none expected, class %0d total %0d",
                   $time, line_class_i, all_lines_i);
        end else begin
          want = line_reports_q.pop_front();
          check_field("line_class", 32'(want.cls), 32'(line_class_i));
          check_field("code_lines", want.code, code_lines_i);
          check_field("cmt_lines", want.comment, cmt_lines_i);
          check_field("blank_lines", want.blank, blank_lines_i);
          check_field("all_lines", want.total, all_lines_i);
        end
      end
      if (in_valid_i && !in_stall_i) take_byte(ch_i);
      pending_lines_o = line_reports_q.size();
    end
  end

endmodule

// ----- test/source_line_classifier_tb.sv -----
// top of the line classifier testbench: reset, byte requests, output stalls and verdict
`timescale 1ns / 1ps
module source_line_classifier_tb;
  import slc_pkg::*;

  localparam int HOLD_CYCLES = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  ch_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  line_class_o;
  logic [31:0] code_lines_o;
  logic [31:0] cmt_lines_o;
  logic [31:0] blank_lines_o;
  logic [31:0] all_lines_o;

  int mismatch_count;
  int pending_lines;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int bytes_sent = 0;

  always #4 clk_i = ~clk_i;

  source_line_classifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_class_o   (line_class_o),
    .code_lines_o   (code_lines_o),
    .cmt_lines_o    (cmt_lines_o),
    .blank_lines_o  (blank_lines_o),
    .all_lines_o    (all_lines_o)
  );

  line_count_checker u_line_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .ch_i            (ch_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_class_i    (line_class_o),
    .code_lines_i    (code_lines_o),
    .cmt_lines_i     (cmt_lines_o),
    .blank_lines_i   (blank_lines_o),
    .all_lines_i     (all_lines_o),
    .mismatch_count_o(mismatch_count),
    .pending_lines_o (pending_lines)
  );

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // called just after a falling edge, returns just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // text byte biased toward the characters that steer the line state
  function automatic logic [7:0] text_byte();
    case ($urandom_range(9))
      0, 1:    return CH_SPACE;
      2:       return CH_SLASH;
      3:       return CH_STAR;
      4:       return CH_LBRACE;
      5:       return CH_RBRACE;
      6, 7:    return 8'($urandom_range(8'h7a, 8'h61));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_line();
    int kind, lead, body;
    kind = $urandom_range(9);
    lead = $urandom_range(3);
    body = $urandom_range(8);
    repeat (lead) begin
      case ($urandom_range(2))
        0:       send_byte(CH_SPACE);
        1:       send_byte(CH_LBRACE);
        default: send_byte(CH_RBRACE);
      endcase
    end
    case (kind)
      0: body = 0;
      1: begin
        send_byte(CH_SLASH);
        body = 0;
      end
      2: begin
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
      end
      3: begin
        send_byte(CH_SLASH);
        send_byte(CH_STAR);
      end
      4: begin
        send_byte(CH_SLASH);
        send_byte(CH_STAR);
        repeat ($urandom_range(4)) send_byte(text_byte());
        send_byte(CH_STAR);
        send_byte(CH_SLASH);
        body = $urandom_range(3);
      end
      // closes a block comment left open on earlier lines
      5: begin
        send_byte(CH_STAR);
        send_byte(CH_SLASH);
      end
      6: send_byte(8'($urandom_range(255)));
      default: ;
    endcase
    repeat (body) send_byte(text_byte());
    send_byte(CH_NL);
  endtask

  initial begin
    logic [7:0] opening [25];
    int target;
    opening = '{CH_SPACE, CH_LBRACE, CH_RBRACE, CH_NL,
                CH_SLASH, CH_NL,
                CH_STAR, CH_NL,
                CH_STAR, CH_STAR, CH_SLASH, CH_NL,
                CH_STAR, CH_SLASH, 8'h78, CH_NL,
                CH_SLASH, CH_SLASH, CH_NL,
                8'h00, 8'hff, CH_NL,
                CH_SLASH, CH_SPACE, CH_NL};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (opening[i]) send_byte(opening[i]);

    // receiver holds off while newline-heavy requests keep coming
    hold_req = 1'b1;
    repeat (80) send_byte($urandom_range(1) ? CH_NL : text_byte());

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      target = bytes_sent + 410;
      while (bytes_sent < target) send_line();
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_lines != 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/slc_pkg.sv
rtl/core/slc_line_fsm.sv
rtl/core/slc_counters.sv
rtl/core/source_line_classifier.sv
rtl/core/slc_checker.sv
test/line_count_checker.sv
test/source_line_classifier_tb.sv
